/* hw/rtl/rlp_pkg.sv */
// Shared constants, types and character helpers for the log line parser.
`default_nettype none

package rlp_pkg;

  // Line and field limits
  localparam int unsigned MAX_LINE_BYTES = 256;
  localparam int unsigned FIELD_CHARS    = 19;
  localparam int unsigned FRAC_DIGITS    = 3;

  // Field widths
  localparam int unsigned CharW   = 8;
  localparam int unsigned StatusW = 32;
  localparam int unsigned CoordW  = 40;
  localparam int unsigned HealthW = 32;
  localparam int unsigned SepW    = 8;
  localparam int unsigned ByteW   = $clog2(MAX_LINE_BYTES + 1);
  localparam int unsigned FposW   = $clog2(FIELD_CHARS + 1);
  localparam int unsigned FracW   = (FRAC_DIGITS > 0) ? $clog2(FRAC_DIGITS + 1) : 1;

  // Header
  localparam int unsigned HdrLen  = 13;
  localparam int unsigned HdrIdxW = $clog2(HdrLen);

  // Field numbers counted by separators
  localparam logic [SepW-1:0] StatusField = 8'd10;
  localparam logic [SepW-1:0] CoordField0 = 8'd11;
  localparam logic [SepW-1:0] HealthField = 8'd14;
  localparam logic [SepW-1:0] SepMax      = 8'd255;
  localparam int unsigned     NumCoords   = 3;

  // Character codes
  localparam logic [CharW-1:0] CharNul   = 8'h00;
  localparam logic [CharW-1:0] CharNl    = 8'h0A;
  localparam logic [CharW-1:0] CharComma = 8'h2C;
  localparam logic [CharW-1:0] CharSemi  = 8'h3B;
  localparam logic [CharW-1:0] CharDot   = 8'h2E;
  localparam logic [CharW-1:0] CharPlus  = 8'h2B;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] CharZero  = 8'h30;

  // Saturation limits
  localparam logic [CoordW-1:0]  CoordCap  = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic [HealthW-1:0] HealthCap = {1'b1, {(HealthW-1){1'b0}}};
  localparam logic [StatusW-1:0] StatusShiftMax = {4'b0000, {(StatusW-4){1'b1}}};

  // Powers of ten for fraction scaling
  function automatic int unsigned pow10(input int unsigned n);
    int unsigned p;
    p = 1;
    for (int unsigned i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  localparam int unsigned Pow10W = $clog2(pow10(FRAC_DIGITS) + 1);

  // Control from the top level to one coordinate unit
  typedef struct packed {
    logic clr;
    logic upd;
  } coord_ctrl_t;

  function automatic logic is_dec(input logic [CharW-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_blank(input logic [CharW-1:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
  endfunction

  function automatic logic is_sign(input logic [CharW-1:0] c);
    return (c == CharPlus) || (c == CharMinus);
  endfunction

  function automatic logic [3:0] dec_val(input logic [CharW-1:0] c);
    logic [CharW-1:0] d;
    d = c - CharZero;
    return d[3:0];
  endfunction

  // Hex digit value; bit 4 flags a valid digit
  function automatic logic [4:0] hex_val(input logic [CharW-1:0] c);
    logic [CharW-1:0] d;
    d = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      return {1'b1, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'b0_0000;
  endfunction

  // Expected header byte at each position
  function automatic logic [CharW-1:0] hdr_char(input logic [HdrIdxW-1:0] idx);
    logic [CharW-1:0] c;
    case (idx)
      4'd0:    c = 8'h23;
      4'd1:    c = 8'h52;
      4'd2:    c = 8'h45;
      4'd3:    c = 8'h46;
      4'd4:    c = 8'h53;
      4'd5:    c = 8'h54;
      4'd6:    c = 8'h41;
      4'd7:    c = 8'h54;
      4'd8:    c = 8'h49;
      4'd9:    c = 8'h4F;
      4'd10:   c = 8'h4E;
      4'd11:   c = 8'h41;
      4'd12:   c = 8'h2C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Scale factor 10^(FRAC_DIGITS - f) for a coordinate with f fraction digits
  function automatic logic [Pow10W-1:0] frac_scale(input logic [FracW-1:0] f);
    logic [Pow10W-1:0] p;
    p = Pow10W'(1);
    for (int unsigned i = 0; i < FRAC_DIGITS; i++) begin
      if (FracW'(i) >= f) begin
        p = Pow10W'(p * Pow10W'(10));
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/rlp_coord.sv */
// One decimal coordinate accumulator with fraction scaling and saturation.
`default_nettype none

module rlp_coord (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire rlp_pkg::coord_ctrl_t        ctrl_i,
  input  wire logic [rlp_pkg::CharW-1:0]   char_i,
  output logic      [rlp_pkg::CoordW-1:0]  value_o,
  output logic                             nonzero_o
);

  typedef enum logic [2:0] {
    PhBefore,
    PhSigned,
    PhInt,
    PhFrac,
    PhStop
  } phase_e;

  localparam int unsigned SumW  = rlp_pkg::CoordW + 4;
  localparam int unsigned ProdW = rlp_pkg::CoordW + rlp_pkg::Pow10W;

  phase_e                           phase_q, phase_d;
  logic [rlp_pkg::CoordW-1:0]       acc_q, acc_d;
  logic                             neg_q, neg_d;
  logic [rlp_pkg::FracW-1:0]        frac_q, frac_d;
  logic [SumW-1:0]                  sum;
  logic [rlp_pkg::CoordW-1:0]       acc_next;
  logic [ProdW-1:0]                 scaled;
  logic [rlp_pkg::CoordW-1:0]       mag;

  // Multiply-add one digit, cap at the magnitude limit
  always_comb begin
    sum = (SumW'(acc_q) << 3) + (SumW'(acc_q) << 1) + SumW'(rlp_pkg::dec_val(char_i));
    acc_next = (sum > SumW'(rlp_pkg::CoordCap)) ? rlp_pkg::CoordCap
                                                 : sum[rlp_pkg::CoordW-1:0];
  end

  // Advance the number scanner
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    frac_d  = frac_q;
    if (ctrl_i.clr) begin
      phase_d = PhBefore;
      acc_d   = '0;
      neg_d   = 1'b0;
      frac_d  = '0;
    end else if (ctrl_i.upd && phase_q != PhStop) begin
      if (rlp_pkg::is_dec(char_i)) begin
        if (phase_q == PhFrac) begin
          if (frac_q < rlp_pkg::FracW'(rlp_pkg::FRAC_DIGITS)) begin
            frac_d = frac_q + rlp_pkg::FracW'(1);
            acc_d  = acc_next;
          end
        end else begin
          phase_d = PhInt;
          acc_d   = acc_next;
        end
      end else if (char_i == rlp_pkg::CharDot && phase_q != PhFrac) begin
        phase_d = PhFrac;
      end else if (phase_q == PhBefore && rlp_pkg::is_blank(char_i)) begin
        phase_d = phase_q;
      end else if (phase_q == PhBefore && rlp_pkg::is_sign(char_i)) begin
        neg_d   = (char_i == rlp_pkg::CharMinus);
        phase_d = PhSigned;
      end else begin
        phase_d = PhStop;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhBefore;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      frac_q  <= '0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      frac_q  <= frac_d;
    end
  end

  // Scale missing fraction digits, saturate, apply sign
  always_comb begin
    scaled = ProdW'(acc_q) * ProdW'(rlp_pkg::frac_scale(frac_q));
    mag    = (scaled > ProdW'(rlp_pkg::CoordCap)) ? rlp_pkg::CoordCap
                                                   : scaled[rlp_pkg::CoordW-1:0];
    if (neg_q) begin
      value_o = ~mag + rlp_pkg::CoordW'(1);
    end else if (mag > rlp_pkg::CoordCap - rlp_pkg::CoordW'(1)) begin
      value_o = rlp_pkg::CoordCap - rlp_pkg::CoordW'(1);
    end else begin
      value_o = mag;
    end
    nonzero_o = (acc_q != '0);
  end

endmodule

`default_nettype wire

/* hw/rtl/refstation_log_line_parser.sv */
// Top level of the streaming log line parser.
//
// Input channel: in_valid_i / in_stall_o carry one line byte per item on
// char_code_i. Output channel: out_valid_o / out_stall_i carry one parsed
// record per line, emitted when a newline or NUL byte arrives; other bytes
// produce nothing. An item moves when valid is high and stall is low.
//
// Throughput: one byte per cycle, except while a terminator waits in the
// input register for a stalled record to be taken. Each byte is captured
// in an input register and then folded into the line state by one
// multiply-add per decimal field; records leave from an output register.
//
// When the receiver stalls, the record holds in the output register and
// ordinary bytes keep flowing; a second terminator waits in the input
// register, which raises in_stall_o until the record is taken.
//
// Reset clears all line state and both valid flags; the header check
// starts armed and all accumulators start at zero.
`default_nettype none

module refstation_log_line_parser (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    char_code_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               header_match_o,
  output logic      [31:0]                   status_word_o,
  output logic signed [39:0]                 x_milli_o,
  output logic signed [39:0]                 y_milli_o,
  output logic signed [39:0]                 z_milli_o,
  output logic signed [31:0]                 health_value_o,
  output logic                               record_valid_o
);

  typedef enum logic [1:0] {
    HpBefore,
    HpNumber,
    HpStop
  } hphase_e;

  localparam int unsigned HSumW = rlp_pkg::HealthW + 4;

  // Input register
  logic                              in_valid_q;
  logic [rlp_pkg::CharW-1:0]         char_q;

  // Line state
  logic [rlp_pkg::ByteW-1:0]         byte_cnt_q, byte_cnt_d;
  logic [rlp_pkg::SepW-1:0]          sep_cnt_q, sep_cnt_d;
  logic [rlp_pkg::FposW-1:0]         fpos_q, fpos_d;
  logic                              hdr_ok_q, hdr_ok_d;
  logic [rlp_pkg::StatusW-1:0]       st_acc_q, st_acc_d;
  logic                              st_seen_q, st_seen_d;
  logic                              st_bad_q, st_bad_d;
  logic [rlp_pkg::HealthW-1:0]       h_acc_q, h_acc_d;
  logic                              h_neg_q, h_neg_d;
  hphase_e                           h_phase_q, h_phase_d;

  // Output register
  logic                              out_valid_q;
  logic                              hdr_match_q;
  logic [rlp_pkg::StatusW-1:0]       status_q;
  logic [rlp_pkg::CoordW-1:0]        coord_q [rlp_pkg::NumCoords];
  logic [rlp_pkg::HealthW-1:0]       health_q;
  logic                              rec_valid_q;

  logic                              is_term;
  logic                              out_free;
  logic                              proc;
  logic                              do_term;
  logic                              do_byte;
  logic                              is_sep;
  logic                              field_upd;
  logic [4:0]                        hex;
  logic [HSumW-1:0]                  h_sum;
  logic [rlp_pkg::StatusW-1:0]       st_word;
  logic [rlp_pkg::HealthW-1:0]       h_word;
  logic                              any_nonzero;

  rlp_pkg::coord_ctrl_t              coord_ctrl [rlp_pkg::NumCoords];
  logic [rlp_pkg::CoordW-1:0]        coord_val  [rlp_pkg::NumCoords];
  logic [rlp_pkg::NumCoords-1:0]     coord_nz;

  // Decide whether the held item can be processed this cycle
  always_comb begin
    is_term  = (char_q == rlp_pkg::CharNl) || (char_q == rlp_pkg::CharNul);
    out_free = !out_valid_q || !out_stall_i;
    proc     = in_valid_q && (!is_term || out_free);
    do_term  = proc && is_term;
    do_byte  = proc && !is_term && (byte_cnt_q < rlp_pkg::ByteW'(rlp_pkg::MAX_LINE_BYTES));
    is_sep   = (char_q == rlp_pkg::CharComma) || (char_q == rlp_pkg::CharSemi);
    field_upd = do_byte && !is_sep
             && (sep_cnt_q >= rlp_pkg::StatusField) && (sep_cnt_q <= rlp_pkg::HealthField)
             && (fpos_q < rlp_pkg::FposW'(rlp_pkg::FIELD_CHARS));
  end

  assign in_stall_o = in_valid_q && !proc;

  // Capture the next item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      char_q <= char_code_i;
    end
  end

  // Track bytes, header, separators and field position
  always_comb begin
    byte_cnt_d = byte_cnt_q;
    sep_cnt_d  = sep_cnt_q;
    fpos_d     = fpos_q;
    hdr_ok_d   = hdr_ok_q;
    if (do_term) begin
      byte_cnt_d = '0;
      sep_cnt_d  = '0;
      fpos_d     = '0;
      hdr_ok_d   = 1'b1;
    end else if (do_byte) begin
      if (byte_cnt_q < rlp_pkg::ByteW'(rlp_pkg::HdrLen)
          && char_q != rlp_pkg::hdr_char(byte_cnt_q[rlp_pkg::HdrIdxW-1:0])) begin
        hdr_ok_d = 1'b0;
      end
      byte_cnt_d = byte_cnt_q + rlp_pkg::ByteW'(1);
      if (is_sep) begin
        if (sep_cnt_q < rlp_pkg::SepMax) begin
          sep_cnt_d = sep_cnt_q + rlp_pkg::SepW'(1);
        end
        fpos_d = '0;
      end else if (field_upd) begin
        fpos_d = fpos_q + rlp_pkg::FposW'(1);
      end
    end
  end

  // Accumulate the hex status field
  always_comb begin
    hex       = rlp_pkg::hex_val(char_q);
    st_acc_d  = st_acc_q;
    st_seen_d = st_seen_q;
    st_bad_d  = st_bad_q;
    if (do_term) begin
      st_acc_d  = '0;
      st_seen_d = 1'b0;
      st_bad_d  = 1'b0;
    end else if (field_upd && sep_cnt_q == rlp_pkg::StatusField) begin
      st_seen_d = 1'b1;
      if (!hex[4]) begin
        st_bad_d = 1'b1;
      end else if (st_acc_q > rlp_pkg::StatusShiftMax) begin
        st_acc_d = '1;
      end else begin
        st_acc_d = {st_acc_q[rlp_pkg::StatusW-5:0], hex[3:0]};
      end
    end
  end

  // Accumulate the decimal health field
  always_comb begin
    h_sum     = (HSumW'(h_acc_q) << 3) + (HSumW'(h_acc_q) << 1)
              + HSumW'(rlp_pkg::dec_val(char_q));
    h_acc_d   = h_acc_q;
    h_neg_d   = h_neg_q;
    h_phase_d = h_phase_q;
    if (do_term) begin
      h_acc_d   = '0;
      h_neg_d   = 1'b0;
      h_phase_d = HpBefore;
    end else if (field_upd && sep_cnt_q == rlp_pkg::HealthField && h_phase_q != HpStop) begin
      if (rlp_pkg::is_dec(char_q)) begin
        h_acc_d   = (h_sum > HSumW'(rlp_pkg::HealthCap)) ? rlp_pkg::HealthCap
                                                         : h_sum[rlp_pkg::HealthW-1:0];
        h_phase_d = HpNumber;
      end else if (h_phase_q == HpBefore && rlp_pkg::is_blank(char_q)) begin
        h_phase_d = HpBefore;
      end else if (h_phase_q == HpBefore && rlp_pkg::is_sign(char_q)) begin
        h_neg_d   = (char_q == rlp_pkg::CharMinus);
        h_phase_d = HpNumber;
      end else begin
        h_phase_d = HpStop;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= '0;
      sep_cnt_q  <= '0;
      fpos_q     <= '0;
      hdr_ok_q   <= 1'b1;
      st_acc_q   <= '0;
      st_seen_q  <= 1'b0;
      st_bad_q   <= 1'b0;
      h_acc_q    <= '0;
      h_neg_q    <= 1'b0;
      h_phase_q  <= HpBefore;
    end else begin
      byte_cnt_q <= byte_cnt_d;
      sep_cnt_q  <= sep_cnt_d;
      fpos_q     <= fpos_d;
      hdr_ok_q   <= hdr_ok_d;
      st_acc_q   <= st_acc_d;
      st_seen_q  <= st_seen_d;
      st_bad_q   <= st_bad_d;
      h_acc_q    <= h_acc_d;
      h_neg_q    <= h_neg_d;
      h_phase_q  <= h_phase_d;
    end
  end

  // Coordinate units, one per field
  for (genvar k = 0; k < rlp_pkg::NumCoords; k++) begin : g_coord
    assign coord_ctrl[k].clr = do_term;
    assign coord_ctrl[k].upd = field_upd
                            && (sep_cnt_q == rlp_pkg::CoordField0 + rlp_pkg::SepW'(k));

    rlp_coord u_coord (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (coord_ctrl[k]),
      .char_i    (char_q),
      .value_o   (coord_val[k]),
      .nonzero_o (coord_nz[k])
    );
  end

  // Form the record from the line state
  always_comb begin
    st_word = (!st_seen_q || st_bad_q) ? rlp_pkg::StatusW'(1) : st_acc_q;
    if (h_neg_q) begin
      h_word = ~h_acc_q + rlp_pkg::HealthW'(1);
    end else if (h_acc_q > rlp_pkg::HealthCap - rlp_pkg::HealthW'(1)) begin
      h_word = rlp_pkg::HealthCap - rlp_pkg::HealthW'(1);
    end else begin
      h_word = h_acc_q;
    end
    any_nonzero = |coord_nz;
  end

  // Hold the record until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_term) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_term) begin
      hdr_match_q <= hdr_ok_q && (byte_cnt_q >= rlp_pkg::ByteW'(rlp_pkg::HdrLen));
      status_q    <= st_word;
      coord_q     <= coord_val;
      health_q    <= h_word;
      rec_valid_q <= !st_word[0] && any_nonzero;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign header_match_o = hdr_match_q;
  assign status_word_o  = status_q;
  assign x_milli_o      = coord_q[0];
  assign y_milli_o      = coord_q[1];
  assign z_milli_o      = coord_q[2];
  assign health_value_o = health_q;
  assign record_valid_o = rec_valid_q;

endmodule

`default_nettype wire

/* hw/rtl/rlp_checker.sv */
// Port-level checks for the log line parser, bound to the top level.
`default_nettype none

module rlp_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [31:0]        status_word_o,
  input wire logic signed [39:0] x_milli_o,
  input wire logic signed [39:0] y_milli_o,
  input wire logic signed [39:0] z_milli_o,
  input wire logic               record_valid_o
);

  // A stalled record stays offered
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("record dropped while stalled");

  // A record never claims validity with status bit 0 set
  a_valid_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_valid_o |-> !status_word_o[0])
    else $error("record valid with status bit 0 set");

  // A valid record has a nonzero coordinate
  a_valid_coord : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_valid_o |-> (x_milli_o != '0) || (y_milli_o != '0)
                                      || (z_milli_o != '0))
    else $error("record valid with all coordinates zero");

  // A new record follows an earlier accepted item
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("record appeared without a matching item");

endmodule

bind refstation_log_line_parser rlp_checker u_rlp_checker (.*);

`default_nettype wire

/* sim/line_check_pkg.sv */
// Record type, character helpers and the line scoreboard for the log line parser bench.
package line_check_pkg;
  import rlp_pkg::*;

  // Parse phase of one number field
  typedef enum logic [2:0] {
    NUM_LEAD,
    NUM_SIGNED,
    NUM_INT,
    NUM_FRAC,
    NUM_DONE
  } num_phase_e;

  // One parsed line as it leaves the block
  typedef struct packed {
    logic                               hdr;
    logic [StatusW-1:0]                 status;
    logic [NumCoords-1:0][CoordW-1:0]   coord;
    logic [HealthW-1:0]                 health;
    logic                               rec_valid;
  } line_record_t;

  // Station header bytes, comma included
  localparam logic [7:0] StationHdr [HdrLen] = '{
    8'h23, 8'h52, 8'h45, 8'h46, 8'h53, 8'h54, 8'h41,
    8'h54, 8'h49, 8'h4F, 8'h4E, 8'h41, 8'h2C
  };

  // Blanks skipped ahead of a number
  localparam logic [7:0] BlankCodes [5] = '{8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CharZero && c <= CharZero + 8'd9;
  endfunction

  function automatic bit is_space(input logic [7:0] c);
    foreach (BlankCodes[i]) begin
      if (c == BlankCodes[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Value of a hex character, -1 if it is not one
  function automatic int hex_digit(input logic [7:0] c);
    if (is_digit(c)) return int'(c) - int'(CharZero);
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  class line_tracker;
    line_record_t expected_q[$];
    int unsigned  errors;

    // Line state
    int unsigned  nbytes;
    int unsigned  nseps;
    int unsigned  fpos;
    bit           hdr_ok;
    logic [31:0]  st_acc;
    bit           st_seen;
    bit           st_bad;
    logic [63:0]  co_acc [NumCoords];
    bit           co_neg [NumCoords];
    num_phase_e   co_ph [NumCoords];
    int unsigned  co_frac [NumCoords];
    logic [63:0]  hl_acc;
    bit           hl_neg;
    num_phase_e   hl_ph;

    function new();
      errors = 0;
      clear_line();
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void clear_line();
      nbytes  = 0;
      nseps   = 0;
      fpos    = 0;
      hdr_ok  = 1'b1;
      st_acc  = '0;
      st_seen = 1'b0;
      st_bad  = 1'b0;
      for (int k = 0; k < NumCoords; k++) begin
        co_acc[k]  = '0;
        co_neg[k]  = 1'b0;
        co_ph[k]   = NUM_LEAD;
        co_frac[k] = 0;
      end
      hl_acc = '0;
      hl_neg = 1'b0;
      hl_ph  = NUM_LEAD;
    endfunction

    function logic [63:0] cap_coord(input logic [63:0] v);
      return (v > 64'(CoordCap)) ? 64'(CoordCap) : v;
    endfunction

    function void fold_status(input logic [7:0] c);
      int h;
      h = hex_digit(c);
      st_seen = 1'b1;
      if (h < 0) begin
        st_bad = 1'b1;
      end else if (st_acc > StatusShiftMax) begin
        st_acc = '1;
      end else begin
        st_acc = {st_acc[27:0], 4'(h)};
      end
    endfunction

    function void fold_coord(input int k, input logic [7:0] c);
      if (co_ph[k] == NUM_DONE) return;
      if (is_digit(c)) begin
        if (co_ph[k] == NUM_FRAC) begin
          // drop fraction digits past the kept precision
          if (co_frac[k] >= FRAC_DIGITS) return;
          co_frac[k]++;
        end else begin
          co_ph[k] = NUM_INT;
        end
        co_acc[k] = cap_coord(co_acc[k] * 10 + (64'(c) - 64'(CharZero)));
      end else if (c == CharDot && co_ph[k] != NUM_FRAC) begin
        co_ph[k] = NUM_FRAC;
      end else if (co_ph[k] == NUM_LEAD && is_space(c)) begin
        // skip leading blank
      end else if (co_ph[k] == NUM_LEAD && (c == CharPlus || c == CharMinus)) begin
        co_neg[k] = (c == CharMinus);
        co_ph[k]  = NUM_SIGNED;
      end else begin
        co_ph[k] = NUM_DONE;
      end
    endfunction

    function void fold_health(input logic [7:0] c);
      logic [63:0] a;
      if (hl_ph == NUM_DONE) return;
      if (is_digit(c)) begin
        a = hl_acc * 10 + (64'(c) - 64'(CharZero));
        hl_acc = (a > 64'(HealthCap)) ? 64'(HealthCap) : a;
        hl_ph = NUM_INT;
      end else if (hl_ph == NUM_LEAD && is_space(c)) begin
        // skip leading blank
      end else if (hl_ph == NUM_LEAD && (c == CharPlus || c == CharMinus)) begin
        hl_neg = (c == CharMinus);
        hl_ph  = NUM_INT;
      end else begin
        hl_ph = NUM_DONE;
      end
    endfunction

    // Build the record that a terminator releases
    function line_record_t close_line();
      line_record_t r;
      logic [63:0]  m;
      bit           nonzero;
      nonzero = 1'b0;
      r.hdr    = hdr_ok && nbytes >= HdrLen;
      r.status = (!st_seen || st_bad) ? 32'd1 : st_acc;
      for (int k = 0; k < NumCoords; k++) begin
        m = co_acc[k];
        for (int unsigned i = co_frac[k]; i < FRAC_DIGITS; i++) begin
          m = cap_coord(m * 10);
        end
        if (m != 0) nonzero = 1'b1;
        if (co_neg[k]) begin
          r.coord[k] = CoordW'(64'd0 - m);
        end else begin
          r.coord[k] = (m > 64'(CoordCap) - 1) ? CoordCap - 1'b1 : CoordW'(m);
        end
      end
      if (hl_neg) begin
        r.health = HealthW'(64'd0 - hl_acc);
      end else begin
        r.health = (hl_acc > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : hl_acc[31:0];
      end
      r.rec_valid = !r.status[0] && nonzero;
      return r;
    endfunction

    // Fold one accepted byte into the line state
    function void note_byte(input logic [7:0] c);
      if (c == CharNl || c == CharNul) begin
        expected_q.push_back(close_line());
        clear_line();
        return;
      end
      if (nbytes >= MAX_LINE_BYTES) return;
      if (nbytes < HdrLen && c != StationHdr[nbytes]) hdr_ok = 1'b0;
      nbytes++;
      if (c == CharComma || c == CharSemi) begin
        if (nseps < SepMax) nseps++;
        fpos = 0;
        return;
      end
      if (nseps < StatusField || nseps > HealthField) return;
      if (fpos >= FIELD_CHARS) return;
      fpos++;
      if (nseps == StatusField) fold_status(c);
      else if (nseps == HealthField) fold_health(c);
      else fold_coord(int'(nseps) - int'(CoordField0), c);
    endfunction

    function void check_field(input string name, input logic [63:0] exp_v, input logic [63:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Compare one delivered record with the oldest expected one
    function void check_record(input line_record_t act);
      line_record_t exp_r;
      if (expected_q.size() == 0) begin
        $error("record delivered with none expected");
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      check_field("header_match", 64'(exp_r.hdr), 64'(act.hdr));
      check_field("status_word", 64'(exp_r.status), 64'(act.status));
      check_field("x_milli", 64'(exp_r.coord[0]), 64'(act.coord[0]));
      check_field("y_milli", 64'(exp_r.coord[1]), 64'(act.coord[1]));
      check_field("z_milli", 64'(exp_r.coord[2]), 64'(act.coord[2]));
      check_field("health_value", 64'(exp_r.health), 64'(act.health));
      check_field("record_valid", 64'(exp_r.rec_valid), 64'(act.rec_valid));
    endfunction
  endclass

endpackage

/* sim/refstation_log_line_parser_tb.sv */
// Self-checking bench for the log line parser: streams lines and checks every record.
module refstation_log_line_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rlp_pkg::*;
  import line_check_pkg::*;

  typedef logic [7:0] line_bytes_t[$];

  typedef enum int {
    RX_FREE,
    RX_RANDOM,
    RX_PATTERN,
    RX_HOLD
  } rx_mode_e;

  localparam int unsigned IdleLimit = 5000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid  = 1'b0;
  logic [7:0]  char_code = 8'h00;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        header_match;
  logic [31:0] status_word;
  logic signed [39:0] x_milli;
  logic signed [39:0] y_milli;
  logic signed [39:0] z_milli;
  logic signed [31:0] health_value;
  logic        record_valid;

  line_tracker tracker = new();

  int unsigned burst_left = 0;
  int unsigned sent_bytes = 0;
  bit          long_hold_req = 1'b0;

  refstation_log_line_parser dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .char_code_i    (char_code),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .header_match_o (header_match),
    .status_word_o  (status_word),
    .x_milli_o      (x_milli),
    .y_milli_o      (y_milli),
    .z_milli_o      (z_milli),
    .health_value_o (health_value),
    .record_valid_o (record_valid)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Note accepted bytes and check delivered records
  always @(posedge clk) begin
    line_record_t seen;
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.note_byte(char_code);
      if (out_valid && !out_stall) begin
        seen.hdr       = header_match;
        seen.status    = status_word;
        seen.coord[0]  = x_milli;
        seen.coord[1]  = y_milli;
        seen.coord[2]  = z_milli;
        seen.health    = health_value;
        seen.rec_valid = record_valid;
        tracker.check_record(seen);
      end
    end
  end

  // Abort when neither channel moves for too long
  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver stall pattern, with an occasional long hold-off
  initial begin
    rx_mode_e    mode;
    int unsigned span;
    int unsigned period;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        mode = RX_HOLD;
      end else if ($urandom_range(0, 19) == 0) begin
        mode = RX_HOLD;
      end else begin
        mode = rx_mode_e'($urandom_range(0, 2));
      end
      span   = (mode == RX_HOLD) ? $urandom_range(300, 600) : $urandom_range(10, 150);
      period = $urandom_range(2, 7);
      for (int unsigned i = 0; i < span; i++) begin
        // start a requested hold-off right away
        if (long_hold_req && mode != RX_HOLD) break;
        @(posedge clk);
        case (mode)
          RX_FREE:    out_stall <= 1'b0;
          RX_RANDOM:  out_stall <= 1'($urandom_range(0, 1));
          RX_PATTERN: out_stall <= (i % period) == 0;
          default:    out_stall <= 1'b1;
        endcase
      end
    end
  end

  // Offer one byte and hold it until accepted; sometimes idle between bursts
  task automatic send_byte(input logic [7:0] c);
    int unsigned pick;
    int unsigned gap;
    if (burst_left == 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) gap = 0;
      else if (pick < 9) gap = $urandom_range(1, 4);
      else gap = $urandom_range(10, 30);
      burst_left = $urandom_range(1, 48);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    char_code <= c;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_line(input line_bytes_t q);
    sent_bytes += q.size();
    foreach (q[i]) send_byte(q[i]);
  endtask

  // Hold the input until every expected record has come
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  function automatic void push_text(ref line_bytes_t q, input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] rand_dec();
    return CharZero + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_hex();
    int unsigned v;
    v = $urandom_range(0, 15);
    if (v < 10) return CharZero + 8'(v);
    return ($urandom_range(0, 1) ? "A" : "a") + 8'(v - 10);
  endfunction

  // Any byte that neither separates fields nor ends the line
  function automatic logic [7:0] rand_filler();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 4) == 0) c = 8'($urandom_range(1, 255));
      else c = 8'($urandom_range(8'h20, 8'h7E));
    end while (c == CharComma || c == CharSemi || c == CharNl || c == CharNul);
    return c;
  endfunction

  function automatic void push_sep(ref line_bytes_t q);
    q.push_back(($urandom_range(0, 3) == 0) ? CharSemi : CharComma);
  endfunction

  // Header plus filler fields one to nine, ending on the status field
  function automatic void record_prefix(ref line_bytes_t q, input int bad_pos,
                                        input logic [7:0] bad_char);
    for (int i = 0; i < HdrLen; i++) q.push_back((i == bad_pos) ? bad_char : StationHdr[i]);
    for (int f = 1; f < StatusField; f++) begin
      repeat ($urandom_range(0, 5)) q.push_back(rand_filler());
      push_sep(q);
    end
  endfunction

  function automatic void add_status(ref line_bytes_t q);
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0: ;
      1: repeat ($urandom_range(9, 12)) q.push_back(rand_hex());
      2: begin
        q.push_back(CharZero);
        q.push_back("x");
        repeat ($urandom_range(1, 4)) q.push_back(rand_hex());
      end
      3: begin
        q.push_back($urandom_range(0, 1) ? CharPlus : CharMinus);
        repeat ($urandom_range(1, 4)) q.push_back(rand_hex());
      end
      4: begin
        repeat ($urandom_range(0, 3)) q.push_back(rand_hex());
        q.push_back(rand_filler());
        repeat ($urandom_range(0, 3)) q.push_back(rand_hex());
      end
      5, 6: q.push_back(CharZero);
      default: begin
        repeat ($urandom_range(0, 7)) q.push_back(rand_hex());
        do c = rand_hex(); while (hex_digit(c) % 2 != 0);
        q.push_back(c);
      end
    endcase
  endfunction

  function automatic void add_number(ref line_bytes_t q, input bit with_frac);
    int unsigned n_int;
    bit          nines;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) q.push_back(BlankCodes[$urandom_range(0, 4)]);
    end
    case ($urandom_range(0, 2))
      1: q.push_back(CharPlus);
      2: q.push_back(CharMinus);
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0: n_int = 0;
      1: n_int = $urandom_range(10, 15);
      default: n_int = $urandom_range(1, 6);
    endcase
    nines = ($urandom_range(0, 3) == 0);
    repeat (n_int) q.push_back(nines ? CharZero + 8'd9 : rand_dec());
    if (with_frac && $urandom_range(0, 1)) begin
      q.push_back(CharDot);
      repeat ($urandom_range(0, 5)) q.push_back(rand_dec());
    end
    if ($urandom_range(0, 5) == 0) q.push_back(rand_filler());
  endfunction

  // Record line with random content, at times with a broken header or long tail
  function automatic void add_record(ref line_bytes_t q);
    int bad_pos;
    bad_pos = -1;
    if ($urandom_range(0, 9) == 0) bad_pos = $urandom_range(0, HdrLen - 1);
    record_prefix(q, bad_pos, rand_filler());
    add_status(q);
    push_sep(q);
    repeat (NumCoords) begin
      add_number(q, 1'b1);
      push_sep(q);
    end
    add_number(q, 1'b0);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        push_sep(q);
        repeat ($urandom_range(0, 6)) q.push_back(rand_filler());
      end
    end
    // run past the line length limit now and then
    if ($urandom_range(0, 19) == 0) repeat ($urandom_range(150, 260)) q.push_back(rand_filler());
    q.push_back(($urandom_range(0, 4) == 0) ? CharNul : CharNl);
  endfunction

  initial begin
    line_bytes_t q;
    int unsigned rnd_lines;
    int unsigned pick;
    int unsigned keep;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Hold off the receiver while the first lines stream in
    long_hold_req = 1'b1;

    // Empty lines with both terminators, then a short line
    q = '{CharNl, CharNul};
    send_line(q);
    q.delete();
    push_text(q, "#RE");
    q.push_back(CharNl);
    send_line(q);

    // Header alone
    q.delete();
    for (int i = 0; i < HdrLen; i++) q.push_back(StationHdr[i]);
    q.push_back(CharNl);
    send_line(q);

    // Plain valid record, and one with all zero coordinates and odd status
    q.delete();
    record_prefix(q, -1, 8'h00);
    push_text(q, "0,1234.567,-0.001,+42,7");
    q.push_back(CharNl);
    send_line(q);
    q.delete();
    record_prefix(q, -1, 8'h00);
    push_text(q, "1F,0,0.000,-0,0");
    q.push_back(CharNul);
    send_line(q);

    // Status syntax: prefix, sign, empty, mixed case
    q.delete();
    record_prefix(q, -1, 8'h00);
    push_text(q, "0x10,1,2,3,-5");
    q.push_back(CharNl);
    send_line(q);
    q.delete();
    record_prefix(q, -1, 8'h00);
    push_text(q, "-1,1,2,3,5;,");
    q.push_back(CharNl);
    send_line(q);
    q.delete();
    record_prefix(q, -1, 8'h00);
    push_text(q, ",1,2,3,5");
    q.push_back(CharNl);
    send_line(q);
    q.delete();
    record_prefix(q, -1, 8'h00);
    push_text(q, "aBcD1234,1,2,3,5");
    q.push_back(CharNl);
    send_line(q);

    // Saturation at both ends of every number
    q.delete();
    record_prefix(q, -1, 8'h00);
    push_text(q, "FFFFFFFFF,9999999999999,-99999999999999,549755813.887,99999999999");
    q.push_back(CharNl);
    send_line(q);
    q.delete();
    record_prefix(q, -1, 8'h00);
    push_text(q, "0,549755813.888,-549755813.888,-549755813.889,-2147483648");
    q.push_back(CharNl);
    send_line(q);
    q.delete();
    record_prefix(q, -1, 8'h00);
    push_text(q, "2,1,1,1,-99999999999");
    q.push_back(CharNl);
    send_line(q);

    // Number syntax: blanks, truncated fraction, exponent, lone sign or dot
    q.delete();
    record_prefix(q, -1, 8'h00);
    push_text(q, "0,");
    foreach (BlankCodes[i]) q.push_back(BlankCodes[i]);
    push_text(q, "-12.34567,1e5,+.5,");
    q.push_back(BlankCodes[1]);
    push_text(q, "+3x");
    q.push_back(CharNl);
    send_line(q);
    q.delete();
    record_prefix(q, -1, 8'h00);
    push_text(q, "0,.,-,inf,+");
    q.push_back(CharNl);
    send_line(q);

    // Fields longer than the character cap
    q.delete();
    record_prefix(q, -1, 8'h00);
    push_text(q, "0,1234567890123456789012,00000000000000000007,3.1,12345678901234567890");
    q.push_back(CharNl);
    send_line(q);

    // Header broken in its last byte
    q.delete();
    record_prefix(q, HdrLen - 1, CharSemi);
    push_text(q, "0,1,2,3,4");
    q.push_back(CharNl);
    send_line(q);

    // Long line: bytes past the limit are dropped
    q.delete();
    record_prefix(q, -1, 8'h00);
    push_text(q, "0,1,2,3,4,");
    repeat (250) q.push_back("A");
    push_text(q, ",5,6");
    q.push_back(CharNl);
    send_line(q);

    // Separator count saturation
    q.delete();
    repeat (MAX_LINE_BYTES) q.push_back(CharComma);
    push_text(q, "5");
    q.push_back(CharNl);
    send_line(q);

    // Extreme byte values, then back-to-back terminators
    q = '{8'hFF, 8'h80, 8'h7F, 8'h01, CharNl, CharNl, CharNul, CharNl, CharNl, CharNl};
    send_line(q);

    wait_drained();

    // Random lines, mostly well formed
    rnd_lines = 0;
    while (rnd_lines < 4 || sent_bytes < 1450) begin
      q.delete();
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        add_record(q);
      end else if (pick < 16) begin
        // cut a record short
        add_record(q);
        keep = $urandom_range(0, q.size() - 2);
        q = q[0:keep];
        q.push_back(CharNl);
      end else if (pick < 18) begin
        repeat ($urandom_range(0, 40)) q.push_back(8'($urandom_range(0, 255)));
        q.push_back(CharNl);
      end else begin
        repeat ($urandom_range(2, 5)) q.push_back($urandom_range(0, 1) ? CharNl : CharNul);
      end
      rnd_lines++;
      send_line(q);
      if ($urandom_range(0, 11) == 0) wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (tracker.pending() != 0) begin
      $error("%0d expected records never delivered", tracker.pending());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/rlp_pkg.sv
hw/rtl/rlp_coord.sv
hw/rtl/refstation_log_line_parser.sv
hw/rtl/rlp_checker.sv
sim/line_check_pkg.sv
sim/refstation_log_line_parser_tb.sv
